// ===== design/ssig_pkg.sv =====
`default_nettype none

package ssig_pkg;

    localparam int MAX_ENTRIES = 10;
    localparam int KEY_CHARS   = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic               op;
        logic [63:0]        station_key;
        logic signed [7:0]  signal_dbm;
        logic [15:0]        battery_level;
    } t_in;

    typedef struct packed {
        logic [3:0]         slot;
        logic [63:0]        entry_key;
        logic signed [7:0]  entry_dbm;
        logic [15:0]        entry_battery;
        logic [3:0]         stored_count;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [63:0]        key;
        logic signed [7:0]  lvl;
        logic [15:0]        bat;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic CMP_KEY_EQ = 1'b0;
    localparam logic CMP_LVL_GT = 1'b1;

    typedef struct packed {
        logic   mode;
        t_entry a;
        t_entry b;
    } t_cmp_req;

    // keep bytes up to the first zero byte, clear the rest
    function automatic logic [63:0] normalize_key(input logic [63:0] k);
        logic [63:0] r;
        logic        live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (k[8*i +: 8] == 8'd0) live = 1'b0;
            if (live) r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/station_signal_table_unit.sv =====
`default_nettype none

// Station table kept sorted by signal level, strongest first. A report (op 0)
// with a non-empty key is looked up; a hit overwrites that entry, a miss
// appends it or replaces the last slot when the table is full. The table is
// then exchange sorted and every entry is sent out in slot order, the final
// one flagged with last. A clear (op 1) sends nothing; so does a report
// whose first key byte is zero. The entries live in one RAM with a single
// read and a single write port, and one shared comparator does the key
// match during lookup and the level compare during the sort, so the RAM
// read port sets the pace; output stalls lengthen the dump phase. The block
// stalls its input until the dump has been handed to the output register;
// the last result may still wait there while the next report is taken. No
// clearing pass runs after reset: only slots below the entry count are
// ever read.
module station_signal_table_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire ssig_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output ssig_pkg::t_out      o_data
);
    import ssig_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOOK    = 3'd1;
    localparam logic [2:0] S_WRITE   = 3'd2;
    localparam logic [2:0] S_SORT    = 3'd3;
    localparam logic [2:0] S_SORT_WB = 3'd4;
    localparam logic [2:0] S_DUMP    = 3'd5;

    // control state
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_a, n_a;        // next read address to issue
    logic [IDX_W-1:0] r_i, n_i;        // sort row
    logic             r_rv, n_rv;      // RAM output holds entry r_ridx
    logic [IDX_W-1:0] r_ridx, n_ridx;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic             r_ovalid, n_ovalid;

    // payload
    t_entry r_item, n_item;
    t_entry r_cur, n_cur;
    t_out   r_out, n_out;

    // RAM and comparator hookup
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    t_cmp_req         cmp_req;
    logic             cmp_true;

    logic [63:0]      norm_key;
    logic [IDX_W-1:0] last_idx;
    logic [CNT_W-1:0] grow_count;
    logic [IDX_W-1:0] miss_pos;
    logic             out_free;

    ssig_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    ssig_cmp u_cmp (
        .i_req (cmp_req),
        .o_true(cmp_true)
    );

    assign norm_key = normalize_key(i_data.station_key);
    assign last_idx = IDX_W'(r_count - 1'b1);
    assign out_free = !r_ovalid || !i_stall;

    // a miss appends while there is room, else takes the last slot
    assign miss_pos   = (r_count < CNT_W'(MAX_ENTRIES)) ? IDX_W'(r_count)
                                                        : IDX_W'(MAX_ENTRIES - 1);
    assign grow_count = (!r_hit && (r_count < CNT_W'(MAX_ENTRIES))) ? r_count + 1'b1
                                                                    : r_count;

    // the comparator checks keys during lookup and levels during the sort
    always_comb begin
        cmp_req.a = rd_data;
        if (r_state == S_SORT) begin
            cmp_req.mode = CMP_LVL_GT;
            cmp_req.b    = r_cur;
        end else begin
            cmp_req.mode = CMP_KEY_EQ;
            cmp_req.b    = r_item;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_a      = r_a;
        n_i      = r_i;
        n_rv     = r_rv;
        n_ridx   = r_ridx;
        n_hit    = r_hit;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_item   = r_item;
        n_cur    = r_cur;
        n_out    = r_out;
        rd_en    = 1'b0;
        rd_addr  = r_a[IDX_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_item;

        // drop the output once it is taken; the dump may refill it below
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.op) begin
                        n_count = '0;
                    end else if (norm_key[7:0] != 8'd0) begin
                        n_item.key = norm_key;
                        n_item.lvl = i_data.signal_dbm;
                        n_item.bat = i_data.battery_level;
                        n_a        = '0;
                        n_rv       = 1'b0;
                        n_hit      = 1'b0;
                        n_state    = (r_count == '0) ? S_WRITE : S_LOOK;
                    end
                end
            end

            S_LOOK: begin
                // stream reads, compare in the cycle after each read
                if (r_a < r_count) begin
                    rd_en  = 1'b1;
                    n_rv   = 1'b1;
                    n_ridx = r_a[IDX_W-1:0];
                    n_a    = r_a + 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    if (cmp_true) begin
                        n_hit   = 1'b1;
                        n_pos   = r_ridx;
                        n_state = S_WRITE;
                    end else if (r_ridx == last_idx) begin
                        n_state = S_WRITE;
                    end
                end
            end

            S_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = r_hit ? r_pos : miss_pos;
                n_count = grow_count;
                n_a     = '0;
                n_i     = '0;
                n_rv    = 1'b0;
                n_state = (grow_count >= CNT_W'(2)) ? S_SORT : S_DUMP;
            end

            S_SORT: begin
                // row r_i is held in r_cur; each later slot swaps with it
                // when its level is strictly greater
                if (r_a < r_count) begin
                    rd_en  = 1'b1;
                    n_rv   = 1'b1;
                    n_ridx = r_a[IDX_W-1:0];
                    n_a    = r_a + 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    if (r_ridx == r_i) begin
                        n_cur = rd_data;
                    end else if (cmp_true) begin
                        wr_en   = 1'b1;
                        wr_addr = r_ridx;
                        wr_data = r_cur;
                        n_cur   = rd_data;
                    end
                    if (r_ridx == last_idx) n_state = S_SORT_WB;
                end
            end

            S_SORT_WB: begin
                // write back the row and open the next one in the same cycle
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_cur;
                n_i     = r_i + 1'b1;
                if ((CNT_W'(r_i) + CNT_W'(2)) < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_i + 1'b1;
                    n_rv    = 1'b1;
                    n_ridx  = r_i + 1'b1;
                    n_a     = CNT_W'(r_i) + CNT_W'(2);
                    n_state = S_SORT;
                end else begin
                    n_a     = '0;
                    n_rv    = 1'b0;
                    n_state = S_DUMP;
                end
            end

            S_DUMP: begin
                if (r_rv && out_free) begin
                    n_ovalid             = 1'b1;
                    n_out.slot           = 4'(r_ridx);
                    n_out.entry_key      = rd_data.key;
                    n_out.entry_dbm      = rd_data.lvl;
                    n_out.entry_battery  = rd_data.bat;
                    n_out.stored_count   = 4'(r_count);
                    n_out.last           = (r_ridx == last_idx);
                end
                // advance the read only when the RAM output is free this cycle
                if ((r_a < r_count) && (!r_rv || out_free)) begin
                    rd_en  = 1'b1;
                    n_rv   = 1'b1;
                    n_ridx = r_a[IDX_W-1:0];
                    n_a    = r_a + 1'b1;
                end else if (r_rv && out_free) begin
                    n_rv = 1'b0;
                end
                if ((r_a == r_count) && (!r_rv || out_free)) n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_a      <= '0;
            r_i      <= '0;
            r_rv     <= 1'b0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_a      <= n_a;
            r_i      <= n_i;
            r_rv     <= n_rv;
            r_hit    <= n_hit;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= n_ridx;
        r_pos  <= n_pos;
        r_item <= n_item;
        r_cur  <= n_cur;
        r_out  <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // the table never holds more than its capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // the flagged final entry sits at the slot just below the count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.last) |-> (4'(o_data.slot + 4'd1) == o_data.stored_count))
        else $error("last flag on wrong slot");

    // after a non-final transfer more of the dump is still coming
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.last) |=> (o_valid || r_state == S_DUMP))
        else $error("dump ended without a last entry");

    // a lookup or sort read never runs past the valid entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> (CNT_W'(r_ridx) < r_count))
        else $error("read beyond the valid entries");

endmodule

`default_nettype wire

// ===== design/ssig_ram.sv =====
`default_nettype none

module ssig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/ssig_cmp.sv =====
`default_nettype none

module ssig_cmp (
    input  wire ssig_pkg::t_cmp_req i_req,
    output logic                    o_true
);
    import ssig_pkg::*;

    always_comb begin
        case (i_req.mode)
            CMP_KEY_EQ: o_true = (i_req.a.key == i_req.b.key);
            CMP_LVL_GT: o_true = (i_req.a.lvl > i_req.b.lvl);
            default:    o_true = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ssig_pkg::*;

    // Report opcodes carried in the op bit of a transfer.
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam int POOL_N      = 14;     // more callsigns than slots, so the table overflows
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off for the pressure phase
    localparam int TAIL_CYCLES = 100;    // idle wait after the final drain, before judging
    localparam int LIMIT_CYCLES = 400000;

    // One row of the directed stimulus table. When typed is set, top is the
    // hand-written slot 0 entry of the resulting dump.
    typedef struct {
        t_in  item;
        bit   typed;
        t_out top;
    } t_dir_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Report side: testbench is the sender.
    logic rpt_valid = 1'b0;
    t_in  rpt_data  = '0;
    logic rpt_stall;

    // Dump side: testbench is the receiver.
    logic dump_valid;
    logic dump_stall = 1'b0;
    t_out dump_data;

    // Mirror of the station table, updated on every accepted report transfer.
    t_entry stations [MAX_ENTRIES];
    int     station_cnt = 0;

    // Dump entries still owed by the block, oldest first.
    t_out dump_due [$];

    t_dir_row dir_rows [$];
    logic [63:0] key_pool [POOL_N];
    int          pool_len [POOL_N];

    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    int  tx_gap_max   = 16;
    int  rx_wait_max  = 16;
    bit  hold_req     = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    station_signal_table_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (rpt_valid),
        .o_stall (rpt_stall),
        .i_data  (rpt_data),
        .o_valid (dump_valid),
        .i_stall (dump_stall),
        .o_data  (dump_data)
    );

    // ------------------------------------------------------------------
    // Table mirror
    // ------------------------------------------------------------------

    // Keep the low KEY_CHARS bytes up to the first zero byte; drop the rest.
    function automatic logic [63:0] trim_key(input logic [63:0] raw);
        logic [63:0] mask;
        int          k;
        mask = '0;
        k    = 0;
        while (k < KEY_CHARS && raw[8*k +: 8] != 8'd0) begin
            mask[8*k +: 8] = 8'hFF;
            k++;
        end
        return raw & mask;
    endfunction

    // Apply one report or clear to the mirror and queue the dump it causes.
    task automatic table_update(input t_in it);
        logic [63:0] key;
        int          pos;
        int          i;
        int          j;
        t_entry      tmp;
        t_out        ent;
        if (it.op == OP_CLEAR) begin
            station_cnt = 0;
            return;
        end
        key = trim_key(it.station_key);
        // Empty callsign: drop the report, nothing is sent.
        if (key[7:0] == 8'd0) return;

        pos = -1;
        for (i = 0; i < station_cnt; i++)
            if (pos < 0 && stations[i].key == key) pos = i;
        if (pos < 0) begin
            // Miss: append, or overwrite the last slot of a full table.
            if (station_cnt < MAX_ENTRIES) begin
                pos = station_cnt;
                station_cnt++;
            end else begin
                pos = MAX_ENTRIES - 1;
            end
        end
        stations[pos].key = key;
        stations[pos].lvl = it.signal_dbm;
        stations[pos].bat = it.battery_level;

        // Exchange sort, strongest first; a later entry moves up only when strictly stronger.
        for (i = 0; i + 1 < station_cnt; i++) begin
            for (j = i + 1; j < station_cnt; j++) begin
                if ($signed(stations[j].lvl) > $signed(stations[i].lvl)) begin
                    tmp         = stations[i];
                    stations[i] = stations[j];
                    stations[j] = tmp;
                end
            end
        end

        for (i = 0; i < station_cnt; i++) begin
            ent.slot          = i[3:0];
            ent.entry_key     = stations[i].key;
            ent.entry_dbm     = stations[i].lvl;
            ent.entry_battery = stations[i].bat;
            ent.stored_count  = station_cnt[3:0];
            ent.last          = (i + 1 == station_cnt);
            dump_due.push_back(ent);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_in report_item(input logic [63:0] key, input logic [7:0] dbm,
                                        input logic [15:0] bat);
        t_in it;
        it.op            = OP_REPORT;
        it.station_key   = key;
        it.signal_dbm    = dbm;
        it.battery_level = bat;
        return it;
    endfunction

    function automatic t_in clear_item(input logic [63:0] junk);
        t_in it;
        it.op            = OP_CLEAR;
        it.station_key   = junk;
        it.signal_dbm    = junk[7:0];
        it.battery_level = junk[15:0];
        return it;
    endfunction

    function automatic t_out dump_entry(input logic [3:0] slot, input logic [63:0] key,
                                        input logic [7:0] dbm, input logic [15:0] bat,
                                        input logic [3:0] cnt, input logic last);
        t_out ent;
        ent.slot          = slot;
        ent.entry_key     = key;
        ent.entry_dbm     = dbm;
        ent.entry_battery = bat;
        ent.stored_count  = cnt;
        ent.last          = last;
        return ent;
    endfunction

    task automatic add_row(input t_in it, input bit typed, input t_out top);
        t_dir_row row;
        row.item  = it;
        row.typed = typed;
        row.top   = top;
        dir_rows.push_back(row);
    endtask

    // Mostly reports on a small pool of callsigns so hits, overflow and ties
    // happen often; the rest are fresh random keys, empty keys and clears.
    function automatic t_in random_item();
        t_in         it;
        int          pick;
        int          idx;
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        it   = report_item({$urandom, $urandom}, 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            it.op = OP_CLEAR;
        end else if (pick < 8) begin
            it.station_key[7:0] = 8'd0;
        end else if (pick >= 20) begin
            idx            = $urandom_range(0, POOL_N - 1);
            it.station_key = key_pool[idx];
            // Pad some short keys with garbage past the terminator.
            if (pool_len[idx] < 7 && $urandom_range(0, 1) == 1)
                it.station_key |= junk & ~((64'd1 << (8 * (pool_len[idx] + 1))) - 64'd1);
        end
        case ($urandom_range(0, 7))
            0: it.signal_dbm = 8'h80;
            1: it.signal_dbm = 8'hFF;
            2: it.signal_dbm = 8'h00;
            3: it.signal_dbm = 8'h7F;
            default: ;
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Report sender
    // ------------------------------------------------------------------

    // Idle for a random gap, then present the transfer and hold it until
    // accepted. Predict the dump at the accepting edge.
    task automatic offer(input t_in it, input bit typed, input t_out top);
        int gap;
        int base;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            rpt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rpt_valid <= 1'b1;
        rpt_data  <= it;
        @(posedge clk);
        while (rpt_stall !== 1'b0) @(posedge clk);
        base = dump_due.size();
        table_update(it);
        if (typed && dump_due.size() > base) dump_due[base] = top;
    endtask

    task automatic go_quiet();
        rpt_valid <= 1'b0;
    endtask

    // Hold the sender until every owed dump entry has been taken.
    task automatic drain();
        while (dump_due.size() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        t_in it;
        int  taken;
        taken = 0;
        while (taken < count) begin
            it = random_item();
            offer(it, 1'b0, '0);
            // Empty-key reports are dropped by the block; do not count them.
            if (it.op == OP_CLEAR || it.station_key[7:0] != 8'd0) taken++;
        end
    endtask

    // ------------------------------------------------------------------
    // Dump receiver
    // ------------------------------------------------------------------

    // Stall for a random wait before each transfer, or for the long
    // hold-off when one is requested; then take the next transfer.
    initial begin : dump_receiver
        int w;
        forever begin
            if (hold_req) begin
                w        = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                w = $urandom_range(0, rx_wait_max);
            end
            if (w > 0) begin
                dump_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            dump_stall <= 1'b0;
            do @(posedge clk); while (dump_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Dump checker
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    // Compare every accepted dump transfer with the oldest owed entry.
    always @(posedge clk) begin : dump_check
        t_out want;
        cycle_cnt++;
        if (rst_n === 1'b1 && dump_valid === 1'b1 && dump_stall === 1'b0) begin
            if (dump_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer, slot %0d key %h",
                                        dump_data.slot, dump_data.entry_key));
            end else begin
                want = dump_due.pop_front();
                if (dump_data.slot !== want.slot)
                    flag_mismatch($sformatf("slot %0d, want %0d",
                                            dump_data.slot, want.slot));
                if (dump_data.entry_key !== want.entry_key)
                    flag_mismatch($sformatf("slot %0d key %h, want %h", want.slot,
                                            dump_data.entry_key, want.entry_key));
                if (dump_data.entry_dbm !== want.entry_dbm)
                    flag_mismatch($sformatf("slot %0d dbm %0d, want %0d", want.slot,
                                            dump_data.entry_dbm, want.entry_dbm));
                if (dump_data.entry_battery !== want.entry_battery)
                    flag_mismatch($sformatf("slot %0d battery %0d, want %0d", want.slot,
                                            dump_data.entry_battery, want.entry_battery));
                if (dump_data.stored_count !== want.stored_count)
                    flag_mismatch($sformatf("slot %0d count %0d, want %0d", want.slot,
                                            dump_data.stored_count, want.stored_count));
                if (dump_data.last !== want.last)
                    flag_mismatch($sformatf("slot %0d last %b, want %b", want.slot,
                                            dump_data.last, want.last));
            end
        end
    end

    // Cycle limit: end the run if the block hangs.
    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        int p;
        int b;
        int r;

        // Build the callsign pool: 1 to 8 nonzero bytes each.
        for (p = 0; p < POOL_N; p++) begin
            pool_len[p] = $urandom_range(1, 8);
            key_pool[p] = '0;
            for (b = 0; b < pool_len[p]; b++)
                key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
        end

        // Directed table. Typed rows carry the slot 0 entry of their dump.
        // First report into an empty table.
        add_row(report_item(64'h41, 8'h00, 16'h0000), 1'b1,
                dump_entry(4'd0, 64'h41, 8'h00, 16'h0000, 4'd1, 1'b1));
        // Clear with every other field at ones; nothing is sent.
        add_row(clear_item('1), 1'b0, '0);
        // Empty key with garbage above it; dropped.
        add_row(report_item(64'hFFFF_FFFF_FFFF_FF00, 8'h7F, 16'hFFFF), 1'b0, '0);
        // Full eight-character key, top level, top battery.
        add_row(report_item('1, 8'h7F, 16'hFFFF), 1'b1,
                dump_entry(4'd0, '1, 8'h7F, 16'hFFFF, 4'd1, 1'b1));
        // Key with a zero byte inside: trimmed there, bottom level.
        add_row(report_item(64'h1122_3344_0055_6677, 8'h80, 16'h0001), 1'b1,
                dump_entry(4'd0, '1, 8'h7F, 16'hFFFF, 4'd2, 1'b0));
        // Same trimmed key with other garbage: a hit.
        add_row(report_item(64'hAB00_0000_0055_6677, 8'hFF, 16'h1234), 1'b0, '0);
        // Fill the table, with ties at -1 and at the top level.
        add_row(report_item(64'h4232, 8'hFF, 16'd100), 1'b0, '0);
        add_row(report_item(64'h43, 8'hFF, 16'd200), 1'b0, '0);
        add_row(report_item(64'h44, 8'd50, 16'd300), 1'b0, '0);
        add_row(report_item(64'h45, 8'hCE, 16'd400), 1'b0, '0);
        add_row(report_item(64'h46, 8'h00, 16'd500), 1'b0, '0);
        add_row(report_item(64'h47, 8'h7F, 16'd600), 1'b0, '0);
        add_row(report_item(64'h48, 8'h80, 16'd700), 1'b0, '0);
        add_row(report_item(64'h49, 8'h01, 16'd800), 1'b0, '0);
        // Table full: new keys overwrite the last slot.
        add_row(report_item(64'h4A, 8'h7E, 16'd900), 1'b0, '0);
        add_row(report_item(64'h4B, 8'h80, 16'd1000), 1'b0, '0);
        // Hit on a full table.
        add_row(report_item(64'h44, 8'h80, 16'h0000), 1'b0, '0);
        add_row(report_item(64'hFFFF_FFFF_FF00_4C4D, 8'h10, 16'hFFFF), 1'b0, '0);
        // All-zero key on a full table; dropped.
        add_row(report_item(64'h0, 8'h00, 16'h0000), 1'b0, '0);
        add_row(clear_item('0), 1'b0, '0);
        add_row(report_item(64'h5A, 8'h80, 16'hFFFF), 1'b1,
                dump_entry(4'd0, 64'h5A, 8'h80, 16'hFFFF, 4'd1, 1'b1));
        add_row(report_item(64'h5A, 8'h7F, 16'h0000), 1'b1,
                dump_entry(4'd0, 64'h5A, 8'h7F, 16'h0000, 4'd1, 1'b1));
        add_row(clear_item({$urandom, $urandom}), 1'b0, '0);

        // Hold reset, then release it once.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with random idling on both sides.
        for (r = 0; r < dir_rows.size(); r++)
            offer(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].top);
        go_quiet();
        drain();

        // Random traffic with idling.
        run_random(70);

        // Back-to-back stretch: no idling on either side.
        tx_gap_max  = 0;
        rx_wait_max = 0;
        run_random(40);

        // Pressure: stall the dump side for a long stretch while reports keep
        // coming, so the block backs up and stalls its input.
        rx_wait_max = 16;
        hold_req    = 1'b1;
        run_random(8);
        go_quiet();
        drain();

        // Random traffic with idling to the end.
        tx_gap_max = 16;
        run_random(64);
        go_quiet();

        // Wait out the last dump plus the block's latency, then judge.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && dump_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
